/* rtl/core/nnsc_pkg.sv */
// Shared types, widths and helpers for the leaf Newton-step unit.
// Used by every module of the block except the generic RAM.
`default_nettype none

package nnsc_pkg;

	// Leaf store geometry.
	localparam int MaxLeaves = 64;
	localparam int LeafW     = $clog2(MaxLeaves);
	localparam int CntW      = $clog2(MaxLeaves + 1);

	// Field widths of the streams.
	localparam int WeightW   = 16;
	localparam int ResidW    = 16;
	localparam int CapW      = 15;
	localparam int PredW     = 16;
	localparam int AccW      = 48;
	localparam int TermW     = 34;
	localparam int DiffW     = 18;
	localparam int DprodW    = 32;
	localparam int DivW      = AccW + 8;

	// Input item packing, lowest bit first.
	localparam int OffLeaf   = 0;
	localparam int OffWeight = OffLeaf + LeafW;
	localparam int OffLabel  = OffWeight + WeightW;
	localparam int OffResid  = OffLabel + 1;
	localparam int OffBag    = OffResid + ResidW;
	localparam int OffCount  = OffBag + 1;
	localparam int OffMask   = OffCount + CntW;
	localparam int InBits    = OffMask + MaxLeaves;
	localparam int STdataW   = ((InBits + 7) / 8) * 8;

	// Result item packing.
	localparam int MTdataW   = ((LeafW + PredW + 7) / 8) * 8;
	localparam int MTuserW   = 3;

	// Queue between front and back; depth must be a power of two.
	localparam int QDepth    = 2;
	localparam int QPtrW     = $clog2(QDepth);
	localparam int QCntW     = $clog2(QDepth + 1);

	localparam logic [CapW-1:0] CapReset = CapW'(2560);
	localparam logic [15:0]     OneQ14   = 16'd16384;

	typedef enum logic {
		OP_OBS    = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	// Command handed from front to back.
	typedef struct packed {
		op_t                     op;
		logic [LeafW-1:0]        leaf;
		logic signed [TermW-1:0] num_term;
		logic signed [TermW-1:0] den_term;
		logic [CntW-1:0]         count;
		logic [MaxLeaves-1:0]    mask;
	} cmd_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Saturating add of a term onto a 48-bit signed sum.
	function automatic logic signed [AccW-1:0] sat_add(
		input logic signed [AccW-1:0]  a,
		input logic signed [TermW-1:0] b
	);
		logic signed [AccW:0] s;
		s = {a[AccW-1], a} + (AccW + 1)'(b);
		if (s[AccW] != s[AccW-1]) begin
			sat_add = s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
		end else begin
			sat_add = s[AccW-1:0];
		end
	endfunction

	// Magnitude of a signed sum as an unsigned value of the same width.
	function automatic logic [AccW-1:0] mag(input logic signed [AccW-1:0] v);
		mag = v[AccW-1] ? (~v + AccW'(1)) : v;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/nnsc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Has no dependencies.
`default_nettype none

module nnsc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/nnsc_div.sv */
// Restoring divider, one quotient bit per cycle, for the leaf step.
// Depends on nnsc_pkg.
`default_nettype none

module nnsc_div import nnsc_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [DivW-1:0] dividend,
	input  wire logic [AccW-1:0] divisor,
	output logic                 done,
	output logic [DivW-1:0]      quot,
	output logic                 rem_nz
);

	localparam int StepW = $clog2(DivW);

	logic             busy_q;
	logic [StepW-1:0] step_q;
	logic [AccW-1:0]  rem_q;
	logic [DivW-1:0]  quo_q;
	logic [AccW-1:0]  dvs_q;
	logic [AccW:0]    shifted;
	logic [AccW:0]    diff;
	logic             ge;

	// One trial subtraction per cycle.
	assign shifted = {rem_q, quo_q[DivW-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = ~diff[AccW];

	// Sequencing of the iterations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= StepW'(DivW - 1);
			end else if (busy_q) begin
				step_q <= step_q - StepW'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[AccW-1:0] : shifted[AccW-1:0];
			quo_q <= {quo_q[DivW-2:0], ge};
		end
	end

	assign quot   = quo_q;
	assign rem_nz = |rem_q;

endmodule

`default_nettype wire

/* rtl/core/nnsc_queue.sv */
// Short command queue between the front and back parts.
// Depends on nnsc_pkg for the command type and depth.
`default_nettype none

module nnsc_queue import nnsc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire cmd_t    push_cmd,
	input  wire logic    pop,
	output cmd_t         pop_cmd,
	output q_stat_t      stat
);

	cmd_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCntW'(1);
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign pop_cmd    = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == QCntW'(QDepth));
	assign stat.empty = (cnt_q == '0);

endmodule

`default_nettype wire

/* rtl/core/nnsc_front.sv */
// Front part: accepts input items, works out the per-observation terms and
// drops out-of-bag observations before queuing. Depends on nnsc_pkg.
`default_nettype none

module nnsc_front import nnsc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [STdataW-1:0] s_axis_tdata,
	input  wire logic               s_axis_tuser,
	output logic                    push,
	output cmd_t                    push_cmd,
	input  wire q_stat_t            q_stat
);

	logic en;

	// Stage 1: captured fields.
	logic                     v_s1;
	op_t                      op_s1;
	logic [LeafW-1:0]         leaf_s1;
	logic [WeightW-1:0]       w_s1;
	logic                     lab_s1;
	logic signed [ResidW-1:0] r_s1;
	logic                     bag_s1;
	logic [CntW-1:0]          cnt_s1;
	logic [MaxLeaves-1:0]     mask_s1;

	// Stage 2: first products.
	logic                     v_s2;
	logic                     keep_s2;
	op_t                      op_s2;
	logic [LeafW-1:0]         leaf_s2;
	logic [WeightW-1:0]       w_s2;
	logic [CntW-1:0]          cnt_s2;
	logic [MaxLeaves-1:0]     mask_s2;
	logic signed [TermW-1:0]  num_s2;
	logic signed [DprodW-1:0] dprod_s2;

	// Stage 3: finished terms.
	logic                     v_s3;
	logic                     keep_s3;
	op_t                      op_s3;
	logic [LeafW-1:0]         leaf_s3;
	logic [CntW-1:0]          cnt_s3;
	logic [MaxLeaves-1:0]     mask_s3;
	logic signed [TermW-1:0]  num_s3;
	logic signed [TermW-1:0]  den_s3;

	logic signed [DiffW-1:0]  y_ext;
	logic signed [DiffW-1:0]  a_diff;
	logic signed [DiffW-1:0]  b_diff;
	logic signed [DprodW:0]   dround;
	logic signed [DiffW-1:0]  dq;

	// The pipeline stalls only when a kept item cannot enter the queue.
	assign en            = !(v_s3 && keep_s3 && q_stat.full);
	assign s_axis_tready = en;

	// The two factors of the denominator term: (y - r) and (1 - y + r).
	assign y_ext  = lab_s1 ? DiffW'(OneQ14) : '0;
	assign a_diff = y_ext - DiffW'(r_s1);
	assign b_diff = DiffW'(OneQ14) - a_diff;

	// Divide by 2^14 truncating toward zero.
	assign dround = (DprodW + 1)'(dprod_s2) + (dprod_s2[DprodW-1] ? (DprodW + 1)'(16383) : '0);
	assign dq     = DiffW'(dround >>> 14);

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Payload of the stages.
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= op_t'(s_axis_tuser);
			leaf_s1  <= s_axis_tdata[OffLeaf +: LeafW];
			w_s1     <= s_axis_tdata[OffWeight +: WeightW];
			lab_s1   <= s_axis_tdata[OffLabel];
			r_s1     <= s_axis_tdata[OffResid +: ResidW];
			bag_s1   <= s_axis_tdata[OffBag];
			cnt_s1   <= s_axis_tdata[OffCount +: CntW];
			mask_s1  <= s_axis_tdata[OffMask +: MaxLeaves];

			op_s2    <= op_s1;
			keep_s2  <= (op_s1 == OP_FINISH) || bag_s1;
			leaf_s2  <= leaf_s1;
			w_s2     <= w_s1;
			cnt_s2   <= cnt_s1;
			mask_s2  <= mask_s1;
			num_s2   <= TermW'($signed({1'b0, w_s1}) * r_s1);
			dprod_s2 <= DprodW'(a_diff * b_diff);

			op_s3    <= op_s2;
			keep_s3  <= keep_s2;
			leaf_s3  <= leaf_s2;
			cnt_s3   <= cnt_s2;
			mask_s3  <= mask_s2;
			num_s3   <= num_s2;
			den_s3   <= TermW'($signed({1'b0, w_s2}) * dq);
		end
	end

	// Hand the command to the queue.
	assign push              = v_s3 && keep_s3 && !q_stat.full;
	assign push_cmd.op       = op_s3;
	assign push_cmd.leaf     = leaf_s3;
	assign push_cmd.num_term = num_s3;
	assign push_cmd.den_term = den_s3;
	assign push_cmd.count    = cnt_s3;
	assign push_cmd.mask     = mask_s3;

endmodule

`default_nettype wire

/* rtl/core/nnsc_back.sv */
// Back part: per-leaf accumulation in a RAM and the finish sequence with the
// shared divider. Depends on nnsc_pkg, nnsc_ram and nnsc_div.
`default_nettype none

module nnsc_back import nnsc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire q_stat_t            q_stat,
	output logic                    pop,
	input  wire cmd_t               pop_cmd,
	input  wire logic [CapW-1:0]    cap_level,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [MTdataW-1:0]      m_axis_tdata,
	output logic [MTuserW-1:0]      m_axis_tuser,
	output logic                    m_axis_tlast
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ACC  = 5'b00010,
		ST_FRD  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [MaxLeaves-1:0]    vld_q;
	logic [LeafW-1:0]        cur_q;
	logic [CntW-1:0]         cnt_q;
	logic [MaxLeaves-1:0]    mask_q;
	logic signed [TermW-1:0] num_term_q;
	logic signed [TermW-1:0] den_term_q;
	logic                    neg_q;
	logic signed [PredW-1:0] res_pred_q;
	logic                    res_valid_q;
	logic                    res_capped_q;
	logic                    cap_seen_q;
	logic                    out_free;
	logic                    is_last;

	// RAM and divider connections.
	logic                    ram_we;
	logic                    ram_re;
	logic [LeafW-1:0]        ram_raddr;
	logic [2*AccW-1:0]       ram_wdata;
	logic [2*AccW-1:0]       ram_rdata;
	logic signed [AccW-1:0]  old_num;
	logic signed [AccW-1:0]  old_den;
	logic                    div_start;
	logic                    div_done;
	logic [DivW-1:0]         div_quot;
	logic                    div_rem_nz;
	logic [DivW-1:0]         cap_ext;
	logic                    capped;
	logic [CapW-1:0]         pred_mag;
	logic [CntW-1:0]         count_sat;

	nnsc_ram #(
		.Width (2 * AccW),
		.Depth (MaxLeaves)
	) u_acc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cur_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	nnsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({mag(old_num), 8'd0}),
		.divisor  (mag(old_den)),
		.done     (div_done),
		.quot     (div_quot),
		.rem_nz   (div_rem_nz)
	);

	// An entry not written since the last clear reads as zero.
	assign old_num   = vld_q[cur_q] ? ram_rdata[2*AccW-1:AccW] : '0;
	assign old_den   = vld_q[cur_q] ? ram_rdata[AccW-1:0] : '0;
	assign ram_wdata = {sat_add(old_num, num_term_q), sat_add(old_den, den_term_q)};

	// Clamp decision from the magnitude quotient and remainder.
	assign cap_ext  = DivW'(cap_level);
	assign capped   = (div_quot > cap_ext) || ((div_quot == cap_ext) && div_rem_nz);
	assign pred_mag = capped ? cap_level : div_quot[CapW-1:0];

	assign count_sat = (pop_cmd.count > CntW'(MaxLeaves)) ? CntW'(MaxLeaves) : pop_cmd.count;
	assign out_free  = !m_axis_tvalid || m_axis_tready;
	assign is_last   = ({1'b0, cur_q} + CntW'(1)) == cnt_q;

	// Control decoding.
	always_comb begin
		pop       = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					pop       = 1'b1;
					ram_re    = 1'b1;
					ram_raddr = (pop_cmd.op == OP_OBS) ? pop_cmd.leaf : '0;
				end
			end
			ST_ACC: begin
				ram_we = 1'b1;
			end
			ST_FRD: begin
				div_start = mask_q[cur_q] && (old_den != '0);
			end
			ST_DIV: begin
			end
			ST_OUT: begin
				if (out_free && !is_last) begin
					ram_re    = 1'b1;
					ram_raddr = cur_q + LeafW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vld_q      <= '0;
			cap_seen_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						if (pop_cmd.op == OP_OBS) begin
							state_q <= ST_ACC;
						end else if (count_sat == '0) begin
							vld_q <= '0;
						end else begin
							state_q <= ST_FRD;
						end
					end
				end
				ST_ACC: begin
					vld_q[cur_q] <= 1'b1;
					state_q      <= ST_IDLE;
				end
				ST_FRD: begin
					state_q <= div_start ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						if (res_capped_q) begin
							cap_seen_q <= 1'b1;
						end
						if (is_last) begin
							vld_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_FRD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the current command and leaf result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					cur_q      <= (pop_cmd.op == OP_OBS) ? pop_cmd.leaf : '0;
					num_term_q <= pop_cmd.num_term;
					den_term_q <= pop_cmd.den_term;
					cnt_q      <= count_sat;
					mask_q     <= pop_cmd.mask;
				end
			end
			ST_FRD: begin
				neg_q        <= old_num[AccW-1] ^ old_den[AccW-1];
				res_valid_q  <= mask_q[cur_q];
				res_pred_q   <= '0;
				res_capped_q <= 1'b0;
			end
			ST_DIV: begin
				if (div_done) begin
					res_capped_q <= capped;
					res_pred_q   <= neg_q ? -$signed({1'b0, pred_mag}) : $signed({1'b0, pred_mag});
				end
			end
			ST_OUT: begin
				if (out_free && !is_last) begin
					cur_q <= cur_q + LeafW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_axis_tdata <= MTdataW'({res_pred_q, cur_q});
			m_axis_tuser <= {res_capped_q && !cap_seen_q, res_capped_q, res_valid_q};
			m_axis_tlast <= is_last;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/node_newton_step_capped_unit.sv */
// Top level of the leaf Newton-step unit: configuration register, front,
// queue and back. Depends on nnsc_pkg, nnsc_front, nnsc_queue and nnsc_back.
//
// Usage. Items enter on the s_axis channel: tuser selects an observation (0)
// or a finish (1). An in-bag observation adds its weighted gradient and
// curvature terms to its leaf's sums. A finish returns one item per leaf
// below its leaf count on m_axis, in leaf order, tlast on the final one, and
// then empties all sums. The cfg channel writes cap_level (Q7.8) and is
// always ready; write it only while the block is idle.
// Flow. The front takes one item per cycle, unless a kept item waits on a full
// queue, into a three-stage pipeline and a two-entry queue. The back handles
// an observation with a RAM read, then a write back. A finish leaves the
// queue, then for each leaf reads its sums and outputs a result; for a present
// leaf with a non-zero denominator the bit-serial divider runs in between.
// Reset. All sums read as zero, cap_level is 10.0 and the first-clamp flag
// is armed again; the block is ready as soon as reset is released.
// Stalls. A stalled receiver holds the result register; the back waits, the
// queue fills and s_axis_tready then drops.
`default_nettype none

module node_newton_step_capped_unit import nnsc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	// leaf_index, obs_weight, label, residual, in_bag, leaf_count, present_mask
	input  wire logic [STdataW-1:0] s_axis_tdata,
	// opcode
	input  wire logic               s_axis_tuser,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CapW-1:0]    cfg_data,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	// out_leaf, prediction
	output logic [MTdataW-1:0]      m_axis_tdata,
	// leaf_valid, was_capped, first_cap
	output logic [MTuserW-1:0]      m_axis_tuser,
	output logic                    m_axis_tlast
);

	logic [CapW-1:0] cap_q;
	logic            push;
	logic            pop;
	cmd_t            push_cmd;
	cmd_t            pop_cmd;
	q_stat_t         q_stat;

	// Configuration register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	nnsc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.push_cmd      (push_cmd),
		.q_stat        (q_stat)
	);

	nnsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.stat     (q_stat)
	);

	nnsc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.pop           (pop),
		.pop_cmd       (pop_cmd),
		.cap_level     (cap_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire
